@@ design/bst_pkg.sv @@
// Shared constants and codes for the bounded set table.
package bst_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = 5;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 16;
	localparam int TYPE_W   = 2;
	localparam int STATUS_W = 3;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_EXISTS = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_GET    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

endpackage

@@ design/bst_req_if.sv @@
// Request channel interface of the bounded set table.
interface bst_req_if;
	logic                               valid;
	logic                               ready;
	logic [bst_pkg::TYPE_W-1:0]         req_type;
	logic signed [bst_pkg::VAL_W-1:0]   value;
	logic [bst_pkg::POS_W-1:0]          position;

	modport source (output valid, output req_type, output value, output position,
		input ready);
	modport sink (input valid, input req_type, input value, input position,
		output ready);
endinterface

@@ design/bst_rsp_if.sv @@
// Response channel interface of the bounded set table.
interface bst_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [bst_pkg::STATUS_W-1:0]       status;
	logic                               found;
	logic signed [bst_pkg::VAL_W-1:0]   item;
	logic [bst_pkg::CNT_W-1:0]          count;

	modport source (output valid, output status, output found, output item,
		output count, input ready);
	modport sink (input valid, input status, input found, input item,
		input count, output ready);
endinterface

@@ design/bst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ design/bst_rem.sv @@
// Bit-serial remainder unit: one dividend bit per cycle.
module bst_rem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bst_pkg::POS_W-1:0]   dividend,
	input  logic [bst_pkg::CNT_W-1:0]   divisor,
	output logic                        done,
	output logic [bst_pkg::CNT_W-1:0]   rem
);
	localparam int STEP_W = (bst_pkg::POS_W > 1) ? $clog2(bst_pkg::POS_W) : 1;

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [bst_pkg::POS_W-1:0]   dvd_q;
	logic [bst_pkg::CNT_W-1:0]   dsr_q;
	logic [bst_pkg::CNT_W-1:0]   rem_q;
	logic [bst_pkg::CNT_W:0]     trial;
	logic [bst_pkg::CNT_W-1:0]   rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[bst_pkg::POS_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = bst_pkg::CNT_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[bst_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= rem_next;
				dvd_q  <= {dvd_q[bst_pkg::POS_W-2:0], 1'b0};
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(bst_pkg::POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

@@ design/bounded_set_table_unit.sv @@
// Top level of the bounded set table: sequencer, entry RAM and remainder unit.
//
// Requests arrive on the req channel (valid/ready) and each produces exactly one
// response on the rsp channel (valid/ready) carrying status, found, item and count.
// The capacity register is written with cfg_we and cfg_wdata, and the user must
// write it only while the block is idle; the block itself does not enforce this.
// Add, remove and exists requests scan the stored entries through the single read
// port of the entry RAM, one entry per cycle; a match ends the scan, and with no
// match every entry below the count is read. A remove that hits then shifts the
// later entries down, one per cycle, through the same port. A get request runs a
// bit-serial remainder of position by the count, then one RAM read at the
// remainder; a get on an empty set answers with the empty status without the
// remainder. One request is in work at a time; req.ready is high whenever the
// sequencer is idle, so the next request can be taken in the cycle after the
// previous response is loaded. The finished response sits in an output register;
// if the receiver stalls with a response pending, the next finished response waits
// in the sequencer and no request is taken meanwhile. Reset clears the count to
// zero and the capacity to 16; the entry RAM is not cleared, since only entries
// below the count are ever read.
module bounded_set_table_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bst_pkg::CNT_W-1:0]   cfg_wdata,
	bst_req_if.sink                     req,
	bst_rsp_if.source                   rsp
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_GETRD = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam int IW = bst_pkg::IDX_W;
	localparam int CW = bst_pkg::CNT_W;

	logic [2:0]                         state_q;
	logic [bst_pkg::TYPE_W-1:0]         type_q;
	logic [bst_pkg::VAL_W-1:0]          value_q;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      cap_q;
	logic [CW-1:0]                      addr_q;
	logic                               vld_s1;
	logic [IW-1:0]                      idx_s1;
	logic [bst_pkg::STATUS_W-1:0]       res_status_q;
	logic                               res_found_q;
	logic [bst_pkg::VAL_W-1:0]          res_item_q;
	logic                               out_valid_q;
	logic [bst_pkg::STATUS_W-1:0]       out_status_q;
	logic                               out_found_q;
	logic [bst_pkg::VAL_W-1:0]          out_item_q;
	logic [CW-1:0]                      out_count_q;

	logic                               accept;
	logic                               out_load;
	logic [CW-1:0]                      limit;
	logic                               hit;
	logic                               more;
	logic                               ram_we;
	logic [IW-1:0]                      ram_waddr;
	logic [bst_pkg::VAL_W-1:0]          ram_wdata;
	logic                               ram_re;
	logic [IW-1:0]                      ram_raddr;
	logic [bst_pkg::VAL_W-1:0]          ram_rdata;
	logic                               rem_start;
	logic                               rem_done;
	logic [CW-1:0]                      rem_val;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign limit     = (cap_q < CW'(bst_pkg::DEPTH)) ? cap_q : CW'(bst_pkg::DEPTH);
	assign hit       = vld_s1 && (ram_rdata == value_q);
	assign more      = (addr_q < count_q);
	assign rem_start = accept && (req.req_type == bst_pkg::REQ_GET) && (count_q != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IW-1:0];
		ram_wdata = value_q;
		ram_re    = 1'b0;
		ram_raddr = addr_q[IW-1:0];
		case (state_q)
			S_SCAN: begin
				ram_re = more && !hit;
				if (!vld_s1 && !more && type_q == bst_pkg::REQ_ADD && count_q < limit) begin
					ram_we = 1'b1;
				end
			end
			S_SHIFT: begin
				ram_re    = more;
				ram_we    = vld_s1;
				ram_waddr = idx_s1 - IW'(1);
				ram_wdata = ram_rdata;
			end
			S_MOD: begin
				ram_re    = rem_done;
				ram_raddr = rem_val[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	bst_ram #(
		.WIDTH (bst_pkg::VAL_W),
		.DEPTH (bst_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bst_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (req.position),
		.divisor  (count_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			type_q       <= bst_pkg::REQ_ADD;
			value_q      <= '0;
			count_q      <= '0;
			cap_q        <= bst_pkg::CAP_RESET;
			addr_q       <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			res_status_q <= bst_pkg::ST_OK;
			res_found_q  <= 1'b0;
			res_item_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= bst_pkg::ST_OK;
			out_found_q  <= 1'b0;
			out_item_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_found_q  <= res_found_q;
				out_item_q   <= res_item_q;
				out_count_q  <= count_q;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						type_q       <= req.req_type;
						value_q      <= req.value;
						addr_q       <= '0;
						vld_s1       <= 1'b0;
						res_status_q <= (req.req_type == bst_pkg::REQ_GET && count_q == '0) ?
							bst_pkg::ST_EMPTY : bst_pkg::ST_OK;
						res_found_q  <= 1'b0;
						res_item_q   <= '0;
						if (req.req_type == bst_pkg::REQ_GET) begin
							if (count_q == '0) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_MOD;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= ram_re;
					idx_s1 <= addr_q[IW-1:0];
					if (ram_re) begin
						addr_q <= addr_q + CW'(1);
					end
					if (hit) begin
						case (type_q)
							bst_pkg::REQ_ADD: begin
								res_status_q <= bst_pkg::ST_PRESENT;
								state_q      <= S_DONE;
							end
							bst_pkg::REQ_REMOVE: begin
								addr_q  <= CW'(idx_s1) + CW'(1);
								state_q <= S_SHIFT;
							end
							default: begin
								res_found_q <= 1'b1;
								state_q     <= S_DONE;
							end
						endcase
					end else if (!vld_s1 && !more) begin
						state_q <= S_DONE;
						case (type_q)
							bst_pkg::REQ_ADD: begin
								if (count_q < limit) begin
									count_q <= count_q + CW'(1);
								end else begin
									res_status_q <= bst_pkg::ST_FULL;
								end
							end
							bst_pkg::REQ_REMOVE: begin
								res_status_q <= bst_pkg::ST_ABSENT;
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					vld_s1 <= ram_re;
					idx_s1 <= addr_q[IW-1:0];
					if (ram_re) begin
						addr_q <= addr_q + CW'(1);
					end
					if (!vld_s1 && !more) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_MOD: begin
					if (rem_done) begin
						state_q <= S_GETRD;
					end
				end
				S_GETRD: begin
					res_item_q <= ram_rdata;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.found  = out_found_q;
	assign rsp.item   = out_item_q;
	assign rsp.count  = out_count_q;

	// The count never grows past the depth of the entry RAM.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(bst_pkg::DEPTH))
		else $error("entry count exceeds depth");

	// The count moves by at most one per request.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |->
			(count_q == $past(count_q) + CW'(1)) || (count_q + CW'(1) == $past(count_q)))
		else $error("entry count jumped");

	// Entries are written only while scanning or shifting.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("entry write outside scan or shift");

	// A new response is loaded only when the output register is free or being drained.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !rsp.ready) |=> out_valid_q && state_q == S_DONE)
		else $error("response overwritten while stalled");
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bounded_set_table_unit with random handshakes.
module testbench;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 48;
	localparam int POOL_SIZE = 20;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [bst_pkg::TYPE_W-1:0] kind;
		logic [bst_pkg::VAL_W-1:0]  value;
		logic [bst_pkg::POS_W-1:0]  position;
	} set_req_t;

	typedef struct packed {
		logic [bst_pkg::STATUS_W-1:0] status;
		logic                         found;
		logic [bst_pkg::VAL_W-1:0]    item;
		logic [bst_pkg::CNT_W-1:0]    count;
	} set_rsp_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bst_pkg::CNT_W-1:0]     cfg_wdata;

	bst_req_if req_ch ();
	bst_rsp_if rsp_ch ();

	bounded_set_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	set_req_t                  requests_todo[$];
	set_rsp_t                  answers_due[$];
	logic [bst_pkg::VAL_W-1:0] members[bst_pkg::DEPTH];
	int                        member_count = 0;
	int                        capacity_now = 16;
	logic [bst_pkg::VAL_W-1:0] value_pool[POOL_SIZE];

	logic req_taken = 1'b0;
	int   burst_left = 4;
	int   gap_left = 0;
	int   stall_mode = 0;
	int   stall_tick = 0;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	// Applies one request to the shadow set and returns the response it must produce.
	function automatic set_rsp_t set_outcome(set_req_t r);
		set_rsp_t o;
		int slot;
		int limit;
		o = '0;
		slot = -1;
		limit = (capacity_now < bst_pkg::DEPTH) ? capacity_now : bst_pkg::DEPTH;
		for (int k = 0; k < member_count; k++) begin
			if (slot < 0 && members[k] == r.value) begin
				slot = k;
			end
		end
		case (r.kind)
			bst_pkg::REQ_ADD: begin
				if (slot >= 0) begin
					o.status = bst_pkg::ST_PRESENT;
				end else if (member_count >= limit) begin
					o.status = bst_pkg::ST_FULL;
				end else begin
					members[member_count] = r.value;
					member_count++;
				end
			end
			bst_pkg::REQ_REMOVE: begin
				if (slot < 0) begin
					o.status = bst_pkg::ST_ABSENT;
				end else begin
					for (int k = slot; k + 1 < member_count; k++) begin
						members[k] = members[k + 1];
					end
					member_count--;
				end
			end
			bst_pkg::REQ_EXISTS: begin
				o.found = (slot >= 0);
			end
			default: begin
				if (member_count == 0) begin
					o.status = bst_pkg::ST_EMPTY;
				end else begin
					o.item = members[int'(r.position) % member_count];
				end
			end
		endcase
		o.count = bst_pkg::CNT_W'(member_count);
		return o;
	endfunction

	function automatic void queue_request(logic [bst_pkg::TYPE_W-1:0] kind,
		logic [bst_pkg::VAL_W-1:0] v, logic [bst_pkg::POS_W-1:0] p);
		set_req_t r;
		r.kind = kind;
		r.value = v;
		r.position = p;
		requests_todo.push_back(r);
	endfunction

	function automatic void refresh_pool();
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int k = 4; k < POOL_SIZE; k++) begin
			value_pool[k] = $urandom;
		end
	endfunction

	function automatic void queue_random(int add_pct);
		logic [bst_pkg::TYPE_W-1:0] kind;
		logic [bst_pkg::VAL_W-1:0]  v;
		logic [bst_pkg::POS_W-1:0]  p;
		int                         pick;
		pick = $urandom_range(0, 99);
		if (pick < add_pct) begin
			kind = bst_pkg::REQ_ADD;
		end else begin
			pick = $urandom_range(0, 9);
			kind = (pick < 4) ? bst_pkg::REQ_REMOVE :
				(pick < 7) ? bst_pkg::REQ_EXISTS : bst_pkg::REQ_GET;
		end
		v = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
			: $urandom;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			p = '0;
		end else if (pick == 1) begin
			p = '1;
		end else if (pick < 6) begin
			p = bst_pkg::POS_W'($urandom_range(0, 40));
		end else begin
			p = bst_pkg::POS_W'($urandom);
		end
		queue_request(kind, v, p);
	endfunction

	task automatic wait_idle();
		while (requests_todo.size() != 0 || answers_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(int cap);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= bst_pkg::CNT_W'(cap);
		capacity_now = cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Request driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= '0;
			req_ch.value <= '0;
			req_ch.position <= '0;
		end else if (!req_ch.valid || req_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (requests_todo.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.req_type <= requests_todo[0].kind;
				req_ch.value <= requests_todo[0].value;
				req_ch.position <= requests_todo[0].position;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response receiver: the stall pattern is picked anew at random whenever the low six bits of stall_tick are all ones.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			stall_tick <= stall_tick + 1;
			case (stall_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
				2: rsp_ch.ready <= ($urandom_range(0, 9) < 2);
				default: rsp_ch.ready <= stall_tick[2];
			endcase
			if (stall_tick[5:0] == 6'd63) begin
				stall_mode <= $urandom_range(0, 3);
			end
		end
	end

	// Monitor: checks each response, then predicts for each accepted request.
	always @(posedge clk) begin
		set_rsp_t want;
		set_req_t got_req;
		req_taken <= req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answers_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected response: st %0d fd %0d item %h cnt %0d",
						rsp_ch.status, rsp_ch.found, rsp_ch.item, rsp_ch.count);
				end
			end else begin
				want = answers_due.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.found !== want.found ||
					rsp_ch.item !== want.item || rsp_ch.count !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch exp/act: st %0d/%0d fd %0d/%0d item %h/%h cnt %0d/%0d",
							want.status, rsp_ch.status, want.found, rsp_ch.found,
							want.item, rsp_ch.item, want.count, rsp_ch.count);
					end
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			got_req = requests_todo.pop_front();
			answers_due.push_back(set_outcome(got_req));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL bounded_set_table_unit");
			$finish;
		end
	end

	initial begin
		int phase_cap[RANDOM_PHASES];
		int phase_add[RANDOM_PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		phase_cap = '{31, 1, 16, 2, 0, 8, 0};
		phase_add = '{60, 35, 50, 40, 30, 45, 40};
		phase_cap[RANDOM_PHASES - 1] = $urandom_range(0, 31);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		write_capacity(16);

		// Empty set, duplicates, extremes, wrapping gets and a shifting remove.
		queue_request(bst_pkg::REQ_GET, 32'h0, 16'h0);
		queue_request(bst_pkg::REQ_REMOVE, 32'h5, 16'h0);
		queue_request(bst_pkg::REQ_EXISTS, 32'h5, 16'hFFFF);
		queue_request(bst_pkg::REQ_ADD, 32'h8000_0000, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'h7FFF_FFFF, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'h8000_0000, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'h0, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'hFFFF_FFFF, 16'h0);
		queue_request(bst_pkg::REQ_EXISTS, 32'hFFFF_FFFF, 16'h0);
		queue_request(bst_pkg::REQ_GET, 32'h0, 16'h0);
		queue_request(bst_pkg::REQ_GET, 32'hFFFF_FFFF, 16'hFFFF);
		queue_request(bst_pkg::REQ_REMOVE, 32'h7FFF_FFFF, 16'h0);
		queue_request(bst_pkg::REQ_GET, 32'h0, 16'h1);
		queue_request(bst_pkg::REQ_REMOVE, 32'h0000_3039, 16'h0);
		queue_request(bst_pkg::REQ_EXISTS, 32'h7FFF_FFFF, 16'h0);
		wait_idle();

		// Full set with a duplicate add checked before the full condition.
		write_capacity(3);
		queue_request(bst_pkg::REQ_ADD, 32'h7FFF_FFFF, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'h0, 16'h0);
		queue_request(bst_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'h2A, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'h2B, 16'h0);
		wait_idle();

		// A capacity of zero keeps the entries but refuses every new value.
		write_capacity(0);
		queue_request(bst_pkg::REQ_ADD, 32'h7, 16'h0);
		queue_request(bst_pkg::REQ_GET, 32'h0, 16'hFFFF);
		queue_request(bst_pkg::REQ_REMOVE, 32'h8000_0000, 16'h0);
		queue_request(bst_pkg::REQ_REMOVE, 32'h0, 16'h0);
		queue_request(bst_pkg::REQ_REMOVE, 32'h2A, 16'h0);
		queue_request(bst_pkg::REQ_ADD, 32'h7, 16'h0);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_capacity(phase_cap[ph]);
			refresh_pool();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				queue_random(phase_add[ph]);
			end
			wait_idle();
		end

		if (mismatch_count == 0 && answers_due.size() == 0) begin
			$display("PASS bounded_set_table_unit");
		end else begin
			$display("FAIL bounded_set_table_unit");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/bst_pkg.sv
design/bst_req_if.sv
design/bst_rsp_if.sv
design/bst_ram.sv
design/bst_rem.sv
design/bounded_set_table_unit.sv
dv/testbench.sv
